>>> sv/kmp_substring_search_defines.svh
// Assertion helpers shared by the search block.
`ifndef KMP_SUBSTRING_SEARCH_DEFINES_SVH
`define KMP_SUBSTRING_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, idle during reset.
`define KMP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, idle during reset.
`define KMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/kmp_pkg.sv
`default_nettype none

package kmp_pkg;

  // Default capacity and text position width
  localparam int unsigned MaxPatternDef   = 64;
  localparam int unsigned PositionBitsDef = 32;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_TEXT    = 2'd2,
    OP_END     = 2'd3
  } op_e;

  typedef struct packed {
    op_e        operation;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] position;
  } out_t;

  // Result offered by the sequencer to the output register
  typedef struct packed {
    logic valid;
    out_t rsp;
  } emit_t;

endpackage

`default_nettype wire

>>> sv/kmp_mem.sv
`default_nettype none

module kmp_mem #(
  parameter int unsigned IdxW = 6
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [IdxW-1:0] waddr_i,
  input  wire logic [7:0]      wpat_i,
  input  wire logic [IdxW-1:0] wfail_i,
  input  wire logic [IdxW-1:0] pat_raddr_i,
  input  wire logic [IdxW-1:0] fail_raddr_i,
  output logic      [7:0]      pat_rdata_o,
  output logic      [IdxW-1:0] fail_rdata_o
);

  localparam int unsigned Depth = 2 ** IdxW;

  logic [7:0]      pat_mem  [Depth];
  logic [IdxW-1:0] fail_mem [Depth];
  logic [7:0]      pat_rdata_q;
  logic [IdxW-1:0] fail_rdata_q;

  // Write pattern byte and its failure entry together
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      pat_mem[waddr_i]  <= wpat_i;
      fail_mem[waddr_i] <= wfail_i;
    end
  end

  // Registered reads, one port per store
  always_ff @(posedge clk_i) begin
    pat_rdata_q  <= pat_mem[pat_raddr_i];
    fail_rdata_q <= fail_mem[fail_raddr_i];
  end

  assign pat_rdata_o  = pat_rdata_q;
  assign fail_rdata_o = fail_rdata_q;

endmodule

`default_nettype wire

>>> sv/kmp_seq.sv
`default_nettype none

module kmp_seq #(
  parameter int unsigned MAX_PATTERN   = 64,
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire kmp_pkg::in_t  in_req_i,
  input  wire logic          slot_free_i,
  output kmp_pkg::emit_t     emit_o
);
  import kmp_pkg::*;

  localparam int unsigned IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned PosW = POSITION_BITS;
  localparam int unsigned SubW = (PosW > LenW) ? PosW : LenW;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PINIT = 5'b00010,
    S_LOOK  = 5'b00100,
    S_TEST  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  match_q, match_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             given_q, given_d;
  logic [PosW-1:0]  here_q, here_d;
  logic [IdxW-1:0]  j_q, j_d;
  logic [7:0]       ch_q, ch_d;
  logic             is_text_q, is_text_d;
  logic             found_q, found_d;
  logic             pos_zero_q, pos_zero_d;

  logic             accept;
  logic             we;
  logic [IdxW-1:0]  wfail;
  logic [IdxW-1:0]  fail_raddr;
  logic [7:0]       pat_rdata;
  logic [IdxW-1:0]  fail_rdata;
  logic             eq;
  logic [LenW-1:0]  step_len;
  logic [SubW-1:0]  here_w, back_w, start_w;
  logic [63:0]      start_ext;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  // Failure read: last entry on a pattern request, else entry below j
  assign fail_raddr = (state_q == S_IDLE) ? IdxW'(len_q - LenW'(1)) : (j_q - IdxW'(1));

  kmp_mem #(
    .IdxW (IdxW)
  ) u_mem (
    .clk_i        (clk_i),
    .we_i         (we),
    .waddr_i      (len_q[IdxW-1:0]),
    .wpat_i       (ch_d),
    .wfail_i      (wfail),
    .pat_raddr_i  (j_q),
    .fail_raddr_i (fail_raddr),
    .pat_rdata_o  (pat_rdata),
    .fail_rdata_o (fail_rdata)
  );

  // Shared compare unit: extend the prefix or fall back
  assign eq       = (pat_rdata == ch_q);
  assign step_len = eq ? (LenW'(j_q) + LenW'(1)) : '0;

  // Start of match: position minus (length - 1), clamped at zero
  assign here_w    = SubW'(here_q);
  assign back_w    = SubW'(len_q) - SubW'(1);
  assign start_w   = (here_w >= back_w) ? (here_w - back_w) : '0;
  assign start_ext = 64'(start_w);

  always_comb begin
    emit_o.valid        = (state_q == S_EMIT);
    emit_o.rsp.found    = found_q;
    emit_o.rsp.position = pos_zero_q ? 32'd0 : start_ext[31:0];
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    match_d    = match_q;
    pos_d      = pos_q;
    given_d    = given_q;
    here_d     = here_q;
    j_d        = j_q;
    ch_d       = ch_q;
    is_text_d  = is_text_q;
    found_d    = found_q;
    pos_zero_d = pos_zero_q;
    we         = 1'b0;
    wfail      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_req_i.operation)
            OP_CLEAR: begin
              len_d   = '0;
              match_d = '0;
              pos_d   = '0;
              given_d = 1'b0;
            end
            OP_PATTERN: begin
              ch_d      = in_req_i.data_byte;
              is_text_d = 1'b0;
              // drop bytes beyond capacity; first byte needs no search
              if (len_q != LenW'(MAX_PATTERN)) begin
                if (len_q == '0) begin
                  we    = 1'b1;
                  len_d = LenW'(1);
                end else begin
                  state_d = S_PINIT;
                end
              end
            end
            OP_TEXT: begin
              here_d    = pos_q;
              ch_d      = in_req_i.data_byte;
              is_text_d = 1'b1;
              if (pos_q != '1) begin
                pos_d = pos_q + PosW'(1);
              end
              if (!given_q) begin
                if (len_q == '0) begin
                  found_d    = 1'b1;
                  pos_zero_d = 1'b1;
                  given_d    = 1'b1;
                  state_d    = S_EMIT;
                end else begin
                  j_d     = (match_q >= len_q) ? '0 : match_q[IdxW-1:0];
                  state_d = S_LOOK;
                end
              end
            end
            OP_END: begin
              if (!given_q) begin
                found_d    = (len_q == '0);
                pos_zero_d = 1'b1;
                state_d    = S_EMIT;
              end
              match_d = '0;
              pos_d   = '0;
              given_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_PINIT: begin
        // start from the failure entry of the last pattern byte
        j_d     = (LenW'(fail_rdata) >= len_q) ? '0 : fail_rdata;
        state_d = S_LOOK;
      end
      S_LOOK: begin
        state_d = S_TEST;
      end
      S_TEST: begin
        if ((j_q != '0) && !eq) begin
          j_d     = (fail_rdata < j_q) ? fail_rdata : '0;
          state_d = S_LOOK;
        end else if (is_text_q) begin
          if (step_len >= len_q) begin
            found_d    = 1'b1;
            pos_zero_d = 1'b0;
            given_d    = 1'b1;
            match_d    = '0;
            state_d    = S_EMIT;
          end else begin
            match_d = step_len;
            state_d = S_IDLE;
          end
        end else begin
          we      = 1'b1;
          wfail   = step_len[IdxW-1:0];
          len_d   = len_q + LenW'(1);
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (slot_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      match_q <= '0;
      pos_q   <= '0;
      given_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      match_q <= match_d;
      pos_q   <= pos_d;
      given_q <= given_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    here_q     <= here_d;
    j_q        <= j_d;
    ch_q       <= ch_d;
    is_text_q  <= is_text_d;
    found_q    <= found_d;
    pos_zero_q <= pos_zero_d;
  end

endmodule

`default_nettype wire

>>> sv/kmp_substring_search.sv
// Knuth-Morris-Pratt substring search.
// Input channel (in_valid_i / in_stall_o / in_req_i) carries requests: clear
// pattern, append pattern byte, text byte, end of text. A request is taken
// when valid is high and stall is low; stall stays high while one request is
// being worked on.
// Output channel (out_valid_o / out_stall_i / out_rsp_o) carries at most one
// result per text: found=1 with the start index of the first match, or, at
// end of text, found=0 (position 0) when nothing matched.
// Sequencing: clear, end without result, the first pattern byte, dropped
// pattern bytes and text bytes after a result finish in the accepting state.
// Any other text byte takes one lookup plus one per failure-table fallback it
// walks through (at most two lookups per byte amortized), or none with an empty
// pattern; a later pattern byte reads the last failure entry first, then looks
// up likewise. Each lookup is a registered read of the pattern and failure
// memories followed by the shared byte compare. Results pass the output register.
// A waiting result does not block the next request; a second result waits
// inside the block while the receiver stalls, holding the input stalled.
// Reset clears pattern length, match state and position; stores need no
// clearing pass.
`default_nettype none

`include "kmp_substring_search_defines.svh"

module kmp_substring_search #(
  parameter int unsigned MAX_PATTERN   = kmp_pkg::MaxPatternDef,
  parameter int unsigned POSITION_BITS = kmp_pkg::PositionBitsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire kmp_pkg::in_t  in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output kmp_pkg::out_t      out_rsp_o
);
  import kmp_pkg::*;

  emit_t emit;
  logic  slot_free;
  logic  out_valid_q, out_valid_d;
  out_t  out_rsp_q;

  kmp_seq #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .slot_free_i (slot_free),
    .emit_o      (emit)
  );

  // Output register frees when empty or when its result is taken
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (emit.valid && slot_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Load result payload
  always_ff @(posedge clk_i) begin
    if (emit.valid && slot_free) begin
      out_rsp_q <= emit.rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Checks
  `KMP_ASSERT_NEXT(a_emit_hold, emit.valid && !slot_free, emit.valid,
                   "pending result dropped while output register busy")
  `KMP_ASSERT_NEXT(a_clear_one_cycle,
                   in_valid_i && !in_stall_o && (in_req_i.operation == OP_CLEAR),
                   !in_stall_o && !emit.valid, "clear request did not finish in one cycle")
  `KMP_ASSERT_NOW(a_notfound_zero, out_valid_o && !out_rsp_o.found,
                  out_rsp_o.position == 32'd0, "not-found result with nonzero position")
  `KMP_ASSERT_NOW(a_emit_stalls_input, emit.valid, in_stall_o,
                  "request accepted while a result is pending")

endmodule

`default_nettype wire
